/* hdl/scl_pkg.sv */
package scl_pkg;

    localparam int CP_WIDTH       = 21;
    localparam int COUNT_WIDTH    = 16;
    localparam int TOTAL_WIDTH    = 16;
    localparam int LANG_WIDTH     = 2;
    localparam int NUM_CLASSES    = 5;
    localparam int QUEUE_DEPTH    = 4;
    localparam int IN_DATA_WIDTH  = 24;
    localparam int OUT_DATA_WIDTH = 88;

    typedef enum logic [2:0] {
        CLS_KANA   = 3'd0,
        CLS_HANGUL = 3'd1,
        CLS_HAN    = 3'd2,
        CLS_LATIN  = 3'd3,
        CLS_OTHER  = 3'd4
    } cls_t;

    typedef enum logic [LANG_WIDTH-1:0] {
        LANG_UNKNOWN  = 2'd0,
        LANG_JAPANESE = 2'd1,
        LANG_ENGLISH  = 2'd2,
        LANG_KOREAN   = 2'd3
    } lang_t;

    typedef struct packed {
        logic counted;
        cls_t cls;
        logic last;
    } item_t;

    function automatic logic in_span(logic [CP_WIDTH-1:0] c,
                                     logic [CP_WIDTH-1:0] lo,
                                     logic [CP_WIDTH-1:0] hi);
        return (c >= lo) && (c <= hi);
    endfunction

    function automatic cls_t classify(logic [CP_WIDTH-1:0] c);
        logic kana;
        logic hangul;
        logic han;
        logic latin;
        kana   = in_span(c, 21'h03040, 21'h030FF) || in_span(c, 21'h031F0, 21'h031FF)
              || in_span(c, 21'h0FF66, 21'h0FF9D);
        hangul = in_span(c, 21'h0AC00, 21'h0D7A3) || in_span(c, 21'h01100, 21'h011FF)
              || in_span(c, 21'h03130, 21'h0318F) || in_span(c, 21'h0A960, 21'h0A97F)
              || in_span(c, 21'h0D7B0, 21'h0D7FF);
        han    = in_span(c, 21'h03400, 21'h04DBF) || in_span(c, 21'h04E00, 21'h09FFF)
              || in_span(c, 21'h0F900, 21'h0FAFF) || in_span(c, 21'h20000, 21'h2FA1F);
        latin  = in_span(c, 21'h00041, 21'h0005A) || in_span(c, 21'h00061, 21'h0007A)
              || in_span(c, 21'h000C0, 21'h0024F) || in_span(c, 21'h0FF21, 21'h0FF3A)
              || in_span(c, 21'h0FF41, 21'h0FF5A);
        if (kana)
            return CLS_KANA;
        else if (hangul)
            return CLS_HANGUL;
        else if (han)
            return CLS_HAN;
        else if (latin)
            return CLS_LATIN;
        else
            return CLS_OTHER;
    endfunction

endpackage

/* hdl/scl_front.sv */
module scl_front
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [scl_pkg::CP_WIDTH-1:0]   code_point,
    input  logic                           has_char,
    input  logic                           last,
    output logic                           q_valid,
    input  logic                           q_ready,
    output scl_pkg::item_t                 q_item
);

    logic           valid_reg;
    logic           valid_next;
    scl_pkg::item_t item_reg;

    assign s_ready = !valid_reg || q_ready;
    assign q_valid = valid_reg;
    assign q_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_ready)
            valid_next = s_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_ready && s_valid)
        begin
            item_reg.counted <= has_char;
            item_reg.cls     <= scl_pkg::classify(code_point);
            item_reg.last    <= last;
        end
    end

endmodule

/* hdl/scl_queue.sv */
module scl_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  scl_pkg::item_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output scl_pkg::item_t out_item
);

    localparam int PTR_WIDTH = $clog2(scl_pkg::QUEUE_DEPTH);
    localparam int CNT_WIDTH = $clog2(scl_pkg::QUEUE_DEPTH + 1);

    scl_pkg::item_t        entry_reg [scl_pkg::QUEUE_DEPTH];
    logic [PTR_WIDTH-1:0]  wr_ptr_reg;
    logic [PTR_WIDTH-1:0]  wr_ptr_next;
    logic [PTR_WIDTH-1:0]  rd_ptr_reg;
    logic [PTR_WIDTH-1:0]  rd_ptr_next;
    logic [CNT_WIDTH-1:0]  count_reg;
    logic [CNT_WIDTH-1:0]  count_next;
    logic                  push;
    logic                  pop;

    assign in_ready  = count_reg != CNT_WIDTH'(scl_pkg::QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_item  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_WIDTH'(scl_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_WIDTH'(scl_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= in_item;
    end

endmodule

/* hdl/scl_back.sv */
module scl_back
#(
    parameter int COUNT_WIDTH = scl_pkg::COUNT_WIDTH
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 q_valid,
    output logic                                 q_ready,
    input  scl_pkg::item_t                       q_item,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [scl_pkg::OUT_DATA_WIDTH-1:0]   m_data
);

    localparam int TW = scl_pkg::TOTAL_WIDTH;
    localparam int NC = scl_pkg::NUM_CLASSES;

    logic [COUNT_WIDTH-1:0] cnt_reg  [NC];
    logic [COUNT_WIDTH-1:0] cnt_next [NC];
    logic [COUNT_WIDTH-1:0] cnt_upd  [NC];
    logic [TW-1:0]          total    [NC];
    logic                   res_valid_reg;
    logic                   res_valid_next;
    logic [scl_pkg::OUT_DATA_WIDTH-1:0] res_data_reg;
    scl_pkg::lang_t         lang;
    logic                   take;

    function automatic logic [TW-1:0] report(logic [COUNT_WIDTH-1:0] v);
        logic [COUNT_WIDTH+TW-1:0] wide;
        wide = {{TW{1'b0}}, v};
        if (wide > (COUNT_WIDTH+TW)'({TW{1'b1}}))
            return {TW{1'b1}};
        else
            return wide[TW-1:0];
    endfunction

    assign q_ready = !q_item.last || !res_valid_reg || m_ready;
    assign take    = q_valid && q_ready;
    assign m_valid = res_valid_reg;
    assign m_data  = res_data_reg;

    always_comb
    begin
        for (int i = 0; i < NC; i++)
        begin
            cnt_upd[i] = cnt_reg[i];
            if (q_item.counted && (int'(q_item.cls) == i) && (cnt_reg[i] != '1))
                cnt_upd[i] = cnt_reg[i] + 1'b1;
            total[i] = report(cnt_upd[i]);
        end

        if ((cnt_upd[scl_pkg::CLS_HANGUL] != '0)
            && (cnt_upd[scl_pkg::CLS_HANGUL] >= cnt_upd[scl_pkg::CLS_KANA]))
            lang = scl_pkg::LANG_KOREAN;
        else if ((cnt_upd[scl_pkg::CLS_KANA] != '0) || (cnt_upd[scl_pkg::CLS_HAN] != '0))
            lang = scl_pkg::LANG_JAPANESE;
        else if (cnt_upd[scl_pkg::CLS_LATIN] != '0)
            lang = scl_pkg::LANG_ENGLISH;
        else
            lang = scl_pkg::LANG_UNKNOWN;

        for (int i = 0; i < NC; i++)
        begin
            cnt_next[i] = cnt_reg[i];
            if (take)
                cnt_next[i] = q_item.last ? '0 : cnt_upd[i];
        end

        res_valid_next = res_valid_reg;
        if (m_ready)
            res_valid_next = 1'b0;
        if (take && q_item.last)
            res_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NC; i++)
                cnt_reg[i] <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < NC; i++)
                cnt_reg[i] <= cnt_next[i];
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && q_item.last)
            res_data_reg <= {6'd0,
                             total[scl_pkg::CLS_OTHER],
                             total[scl_pkg::CLS_LATIN],
                             total[scl_pkg::CLS_HAN],
                             total[scl_pkg::CLS_HANGUL],
                             total[scl_pkg::CLS_KANA],
                             lang};
    end

endmodule

/* hdl/script_count_language_guess_top.sv */
// Script counter and language guess.
// Input stream (s_axis_*): one decoded code point per transaction in tdata,
// tuser set when the transaction carries a character, tlast on the final
// transaction of a text. Output stream (m_axis_*): one transaction per text,
// sent for each input transaction with tlast set, holding the language guess
// and the five saturated class totals.
// Throughput: one input transaction per cycle, set by the single classify stage
// and the counter update in the back end, except while a receiver stall fills the queue.
// m_axis_tvalid rises once the closing input transaction has passed the classify
// register, the queue and the result register, in that order.
// While the receiver stalls, the result register holds its transaction and
// input keeps flowing until a further closing transaction reaches the back
// end; the 4-entry queue then fills and s_axis_tready drops.
// Reset clears the counters, the queue and both valid flags; no clearing
// pass is needed, so input is taken from the first cycle after reset.
module script_count_language_guess_top
#(
    parameter int COUNT_WIDTH = scl_pkg::COUNT_WIDTH
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [scl_pkg::IN_DATA_WIDTH-1:0]    s_axis_tdata,  // code_point
    input  logic                                 s_axis_tuser,  // has_char
    input  logic                                 s_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // language, kana_total, hangul_total, han_total, latin_total, other_total
    output logic [scl_pkg::OUT_DATA_WIDTH-1:0]   m_axis_tdata
);

    logic           f_valid;
    logic           f_ready;
    scl_pkg::item_t f_item;
    logic           b_valid;
    logic           b_ready;
    scl_pkg::item_t b_item;

    scl_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .code_point (s_axis_tdata[scl_pkg::CP_WIDTH-1:0]),
        .has_char   (s_axis_tuser),
        .last       (s_axis_tlast),
        .q_valid    (f_valid),
        .q_ready    (f_ready),
        .q_item     (f_item)
    );

    scl_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_item  (b_item)
    );

    scl_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (b_valid),
        .q_ready (b_ready),
        .q_item  (b_item),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_data  (m_axis_tdata)
    );

endmodule

/* tb/script_count_language_guess_top_tb.sv */
module script_count_language_guess_top_tb;

    localparam int OUT_DATA_WIDTH = scl_pkg::OUT_DATA_WIDTH;
    localparam int IN_DATA_WIDTH  = scl_pkg::IN_DATA_WIDTH;
    localparam int CP_WIDTH       = scl_pkg::CP_WIDTH;
    localparam int COUNT_WIDTH    = scl_pkg::COUNT_WIDTH;
    localparam int TOTAL_WIDTH    = scl_pkg::TOTAL_WIDTH;
    localparam int LANG_WIDTH     = scl_pkg::LANG_WIDTH;
    localparam int NUM_CLASSES    = scl_pkg::NUM_CLASSES;

    typedef scl_pkg::cls_t  cls_t;
    typedef scl_pkg::lang_t lang_t;

    localparam cls_t  CLS_KANA      = scl_pkg::CLS_KANA;
    localparam cls_t  CLS_HANGUL    = scl_pkg::CLS_HANGUL;
    localparam cls_t  CLS_HAN       = scl_pkg::CLS_HAN;
    localparam cls_t  CLS_LATIN     = scl_pkg::CLS_LATIN;
    localparam cls_t  CLS_OTHER     = scl_pkg::CLS_OTHER;
    localparam lang_t LANG_UNKNOWN  = scl_pkg::LANG_UNKNOWN;
    localparam lang_t LANG_JAPANESE = scl_pkg::LANG_JAPANESE;
    localparam lang_t LANG_ENGLISH  = scl_pkg::LANG_ENGLISH;
    localparam lang_t LANG_KOREAN   = scl_pkg::LANG_KOREAN;

    localparam int CYCLE_LIMIT = 200_000;
    localparam int NUM_SPANS   = 17;
    localparam int DIR_ROWS    = 26;

    typedef struct packed {
        logic [OUT_DATA_WIDTH-TOTAL_WIDTH*5-LANG_WIDTH-1:0] pad;
        logic [TOTAL_WIDTH-1:0] other;
        logic [TOTAL_WIDTH-1:0] latin;
        logic [TOTAL_WIDTH-1:0] han;
        logic [TOTAL_WIDTH-1:0] hangul;
        logic [TOTAL_WIDTH-1:0] kana;
        lang_t                  language;
    } text_report_t;

    typedef struct {
        logic [CP_WIDTH-1:0] cp;
        logic                has_char;
        logic                last;
        logic                fixed;
        text_report_t        want;
    } code_item_t;

    typedef struct packed {
        logic                   fixed;
        logic [CP_WIDTH-1:0]    cp;
        logic                   has_char;
        logic                   last;
        lang_t                  language;
        logic [TOTAL_WIDTH-1:0] kana;
        logic [TOTAL_WIDTH-1:0] hangul;
        logic [TOTAL_WIDTH-1:0] han;
        logic [TOTAL_WIDTH-1:0] latin;
        logic [TOTAL_WIDTH-1:0] other;
    } dir_row_t;

    localparam logic [CP_WIDTH-1:0] SPAN_LO [NUM_SPANS] = '{
        21'h03040, 21'h031F0, 21'h0FF66,
        21'h0AC00, 21'h01100, 21'h03130, 21'h0A960, 21'h0D7B0,
        21'h03400, 21'h04E00, 21'h0F900, 21'h20000,
        21'h00041, 21'h00061, 21'h000C0, 21'h0FF21, 21'h0FF41
    };
    localparam logic [CP_WIDTH-1:0] SPAN_HI [NUM_SPANS] = '{
        21'h030FF, 21'h031FF, 21'h0FF9D,
        21'h0D7A3, 21'h011FF, 21'h0318F, 21'h0A97F, 21'h0D7FF,
        21'h04DBF, 21'h09FFF, 21'h0FAFF, 21'h2FA1F,
        21'h0005A, 21'h0007A, 21'h0024F, 21'h0FF3A, 21'h0FF5A
    };
    localparam cls_t SPAN_CLS [NUM_SPANS] = '{
        CLS_KANA, CLS_KANA, CLS_KANA,
        CLS_HANGUL, CLS_HANGUL, CLS_HANGUL, CLS_HANGUL, CLS_HANGUL,
        CLS_HAN, CLS_HAN, CLS_HAN, CLS_HAN,
        CLS_LATIN, CLS_LATIN, CLS_LATIN, CLS_LATIN, CLS_LATIN
    };

    // fixed, code point, has_char, last, then the typed report where fixed
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        {1'b1, 21'h000000, 1'b0, 1'b1, LANG_UNKNOWN, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        {1'b1, 21'h1FFFFF, 1'b1, 1'b1, LANG_UNKNOWN, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1},
        {1'b0, 21'h10FFFF, 1'b1, 1'b0, LANG_UNKNOWN, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        {1'b1, 21'h00D800, 1'b1, 1'b1, LANG_UNKNOWN, 16'd0, 16'd0, 16'd0, 16'd0, 16'd2},
        {1'b0, 21'h003040, 1'b1, 1'b0, LANG_UNKNOWN, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        {1'b0, 21'h0030FF, 1'b1, 1'b0, LANG_UNKNOWN, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        {1'b0, 21'h00FF9D, 1'b1, 1'b0, LANG_UNKNOWN, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        {1'b0, 21'h00AC00, 1'b1, 1'b0, LANG_UNKNOWN, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        {1'b0, 21'h00D7A3, 1'b1, 1'b1, LANG_UNKNOWN, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        {1'b0, 21'h001100, 1'b1, 1'b0, LANG_UNKNOWN, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        {1'b0, 21'h00D7FF, 1'b1, 1'b0, LANG_UNKNOWN, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        {1'b0, 21'h003040, 1'b1, 1'b0, LANG_UNKNOWN, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        {1'b0, 21'h000000, 1'b0, 1'b1, LANG_UNKNOWN, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        {1'b0, 21'h004E00, 1'b1, 1'b0, LANG_UNKNOWN, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        {1'b0, 21'h02FA1F, 1'b1, 1'b0, LANG_UNKNOWN, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        {1'b0, 21'h020000, 1'b1, 1'b1, LANG_UNKNOWN, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        {1'b0, 21'h000041, 1'b1, 1'b0, LANG_UNKNOWN, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        {1'b0, 21'h00007A, 1'b1, 1'b0, LANG_UNKNOWN, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        {1'b0, 21'h00FF21, 1'b1, 1'b0, LANG_UNKNOWN, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        {1'b0, 21'h00FF5A, 1'b1, 1'b1, LANG_UNKNOWN, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        {1'b0, 21'h000040, 1'b1, 1'b0, LANG_UNKNOWN, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        {1'b0, 21'h00005B, 1'b1, 1'b0, LANG_UNKNOWN, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        {1'b0, 21'h00024F, 1'b1, 1'b1, LANG_UNKNOWN, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        {1'b0, 21'h0031FF, 1'b1, 1'b0, LANG_UNKNOWN, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        {1'b0, 21'h003130, 1'b1, 1'b0, LANG_UNKNOWN, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        {1'b0, 21'h00A960, 1'b1, 1'b1, LANG_UNKNOWN, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}
    };

    logic                      clk;
    logic                      rst_n         = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [IN_DATA_WIDTH-1:0]  s_axis_tdata  = '0;  // code_point
    logic                      s_axis_tuser  = 1'b0; // has_char
    logic                      s_axis_tlast  = 1'b0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    // language, kana_total, hangul_total, han_total, latin_total, other_total
    logic [OUT_DATA_WIDTH-1:0] m_axis_tdata;

    logic [COUNT_WIDTH-1:0] script_tally [NUM_CLASSES] = '{default: '0};
    code_item_t             text_feed [$];
    text_report_t           pending_reports [$];
    code_item_t             held_item;
    int                     feed_idle_pct  = 0;
    int                     drain_idle_pct = 0;
    int                     err_count      = 0;
    int                     cycle_count    = 0;

    script_count_language_guess_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic cls_t script_of(logic [CP_WIDTH-1:0] cp);
        for (int k = 0; k < NUM_SPANS; k++)
        begin
            if (cp >= SPAN_LO[k] && cp <= SPAN_HI[k])
                return SPAN_CLS[k];
        end
        return CLS_OTHER;
    endfunction

    function automatic logic [TOTAL_WIDTH-1:0] clamp_total(logic [COUNT_WIDTH-1:0] v);
        return (v > 'hFFFF) ? {TOTAL_WIDTH{1'b1}} : TOTAL_WIDTH'(v);
    endfunction

    task automatic absorb_item(code_item_t item);
        cls_t         cls;
        text_report_t rep;
        if (item.has_char)
        begin
            cls = script_of(item.cp);
            if (script_tally[int'(cls)] != {COUNT_WIDTH{1'b1}})
                script_tally[int'(cls)] = script_tally[int'(cls)] + 1'b1;
        end
        if (item.last)
        begin
            rep.pad    = '0;
            rep.kana   = clamp_total(script_tally[int'(CLS_KANA)]);
            rep.hangul = clamp_total(script_tally[int'(CLS_HANGUL)]);
            rep.han    = clamp_total(script_tally[int'(CLS_HAN)]);
            rep.latin  = clamp_total(script_tally[int'(CLS_LATIN)]);
            rep.other  = clamp_total(script_tally[int'(CLS_OTHER)]);
            if (script_tally[int'(CLS_HANGUL)] != 0
                && script_tally[int'(CLS_HANGUL)] >= script_tally[int'(CLS_KANA)])
                rep.language = LANG_KOREAN;
            else if (script_tally[int'(CLS_KANA)] != 0 || script_tally[int'(CLS_HAN)] != 0)
                rep.language = LANG_JAPANESE;
            else if (script_tally[int'(CLS_LATIN)] != 0)
                rep.language = LANG_ENGLISH;
            else
                rep.language = LANG_UNKNOWN;
            pending_reports.push_back(item.fixed ? item.want : rep);
            script_tally = '{default: '0};
        end
    endtask

    task automatic match_field(string label, logic [TOTAL_WIDTH-1:0] want,
                               logic [TOTAL_WIDTH-1:0] got);
        if (want !== got)
        begin
            $display("%0t mismatch %s: expected %0h, actual %0h", $time, label, want, got);
            err_count++;
        end
    endtask

    task automatic check_report(logic [OUT_DATA_WIDTH-1:0] raw);
        text_report_t got;
        text_report_t want;
        got = raw;
        if (pending_reports.size() == 0)
        begin
            $display("%0t unexpected result: expected none, actual %0h", $time, raw);
            err_count++;
        end
        else
        begin
            want = pending_reports.pop_front();
            match_field("language", TOTAL_WIDTH'(want.language), TOTAL_WIDTH'(got.language));
            match_field("kana_total", want.kana, got.kana);
            match_field("hangul_total", want.hangul, got.hangul);
            match_field("han_total", want.han, got.han);
            match_field("latin_total", want.latin, got.latin);
            match_field("other_total", want.other, got.other);
            match_field("pad", TOTAL_WIDTH'(want.pad), TOTAL_WIDTH'(got.pad));
        end
    endtask

    function automatic logic [CP_WIDTH-1:0] pick_code_point(int first_span, int last_span);
        int k;
        k = $urandom_range(last_span, first_span);
        case ($urandom_range(9))
            0, 1:    return CP_WIDTH'($urandom);
            2:       return CP_WIDTH'($urandom_range(16'hFFFF));
            3:
            begin
                case ($urandom_range(3))
                    0:       return SPAN_LO[k] - 1'b1;
                    1:       return SPAN_LO[k];
                    2:       return SPAN_HI[k];
                    default: return SPAN_HI[k] + 1'b1;
                endcase
            end
            default: return SPAN_LO[k] + CP_WIDTH'($urandom_range(SPAN_HI[k] - SPAN_LO[k]));
        endcase
    endfunction

    task automatic push_item(logic [CP_WIDTH-1:0] cp, logic has_char, logic last);
        code_item_t item;
        item.cp       = cp;
        item.has_char = has_char;
        item.last     = last;
        item.fixed    = 1'b0;
        item.want     = '0;
        text_feed.push_back(item);
    endtask

    task automatic queue_random_texts(int n_items);
        int queued;
        int len;
        int first_span;
        int last_span;
        queued = 0;
        while (queued < n_items)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(60, 1) : $urandom_range(10, 1);
            // bias each text towards a range of spans: all scripts, Latin, kana/hangul/han or kana/hangul
            case ($urandom_range(3))
                0:
                begin
                    first_span = 0;
                    last_span  = NUM_SPANS - 1;
                end
                1:
                begin
                    first_span = 12;
                    last_span  = NUM_SPANS - 1;
                end
                2:
                begin
                    first_span = 0;
                    last_span  = 11;
                end
                default:
                begin
                    first_span = 0;
                    last_span  = 7;
                end
            endcase
            for (int i = 0; i < len; i++)
                push_item(pick_code_point(first_span, last_span), $urandom_range(11) != 0,
                          i == len - 1);
            queued += len;
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (text_feed.size() != 0 || s_axis_tvalid || pending_reports.size() != 0);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                absorb_item(held_item);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (text_feed.size() != 0 && $urandom_range(99) >= feed_idle_pct)
                begin
                    held_item = text_feed.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= IN_DATA_WIDTH'(held_item.cp);
                    s_axis_tuser  <= held_item.has_char;
                    s_axis_tlast  <= held_item.last;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_report(m_axis_tdata);
            m_axis_tready <= ($urandom_range(99) >= drain_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("script_count_language_guess_top_tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        code_item_t row_item;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        feed_idle_pct  = 38;
        drain_idle_pct = 68;
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            row_item.cp              = DIRECTED[r].cp;
            row_item.has_char        = DIRECTED[r].has_char;
            row_item.last            = DIRECTED[r].last;
            row_item.fixed           = DIRECTED[r].fixed;
            row_item.want.pad        = '0;
            row_item.want.language   = DIRECTED[r].language;
            row_item.want.kana       = DIRECTED[r].kana;
            row_item.want.hangul     = DIRECTED[r].hangul;
            row_item.want.han        = DIRECTED[r].han;
            row_item.want.latin      = DIRECTED[r].latin;
            row_item.want.other      = DIRECTED[r].other;
            text_feed.push_back(row_item);
        end
        queue_random_texts(383);
        wait_drained();

        feed_idle_pct  = 68;
        drain_idle_pct = 38;
        queue_random_texts(383);
        wait_drained();

        feed_idle_pct  = 0;
        drain_idle_pct = 0;
        queue_random_texts(384);
        // close with an empty text, then a one-letter text
        push_item(21'h000000, 1'b0, 1'b1);
        push_item(21'h000041, 1'b1, 1'b1);
        wait_drained();

        repeat (10) @(posedge clk);
        if (err_count == 0)
            $display("script_count_language_guess_top_tb OK");
        else
            $display("script_count_language_guess_top_tb NOT OK");
        $finish;
    end

endmodule

/* filelist.f */
hdl/scl_pkg.sv
hdl/scl_front.sv
hdl/scl_queue.sv
hdl/scl_back.sv
hdl/script_count_language_guess_top.sv
tb/script_count_language_guess_top_tb.sv
